### src/wdv_pkg.sv
// Package for the WOFF2 directory validator: constants, phase codes, status codes.
// No dependencies.
package wdv_pkg;

  localparam int unsigned CountBits = 25;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  localparam logic [31:0] SigWoff2 = 32'h774F4632;
  localparam logic [31:0] SigTtcf  = 32'h74746366;
  localparam logic [31:0] TagGlyf  = 32'h676C7966;
  localparam logic [31:0] TagLoca  = 32'h6C6F6361;
  localparam logic [31:0] CVer1    = 32'h00010000;
  localparam logic [31:0] CVer2    = 32'h00020000;

  localparam logic [3:0] PhHdr    = 4'd0;
  localparam logic [3:0] PhFlags  = 4'd1;
  localparam logic [3:0] PhTag    = 4'd2;
  localparam logic [3:0] PhOrig   = 4'd3;
  localparam logic [3:0] PhTlen   = 4'd4;
  localparam logic [3:0] PhCver   = 4'd5;
  localparam logic [3:0] PhNfonts = 4'd6;
  localparam logic [3:0] PhFcount = 4'd7;
  localparam logic [3:0] PhFflav  = 4'd8;
  localparam logic [3:0] PhFidx   = 4'd9;
  localparam logic [3:0] PhDone   = 4'd10;

  localparam logic [4:0] StOk        = 5'd0;
  localparam logic [4:0] StTooLarge  = 5'd1;
  localparam logic [4:0] StTooShort  = 5'd2;
  localparam logic [4:0] StSig       = 5'd3;
  localparam logic [4:0] StIncHdr    = 5'd4;
  localparam logic [4:0] StLenMis    = 5'd5;
  localparam logic [4:0] StNoTables  = 5'd6;
  localparam logic [4:0] StReserved  = 5'd7;
  localparam logic [4:0] StSizeZero  = 5'd8;
  localparam logic [4:0] StSizeLimit = 5'd9;
  localparam logic [4:0] StTblCount  = 5'd10;
  localparam logic [4:0] StBadDir    = 5'd11;
  localparam logic [4:0] StGlyfLim   = 5'd12;
  localparam logic [4:0] StInterLim  = 5'd13;
  localparam logic [4:0] StBadColl   = 5'd14;
  localparam logic [4:0] StFontCount = 5'd15;
  localparam logic [4:0] StRefs      = 5'd16;

  localparam logic [2:0] RegMaxInput = 3'd0;
  localparam logic [2:0] RegMaxFinal = 3'd1;
  localparam logic [2:0] RegMaxInter = 3'd2;
  localparam logic [2:0] RegMaxGlyf  = 3'd3;
  localparam logic [2:0] RegMaxTbl   = 3'd4;
  localparam logic [2:0] RegMaxFonts = 3'd5;
  localparam logic [2:0] RegMaxRefs  = 3'd6;

  typedef struct packed {
    logic [24:0] max_input;
    logic [31:0] max_final;
    logic [31:0] max_inter;
    logic [31:0] max_glyf;
    logic [15:0] max_tables;
    logic [15:0] max_fonts;
    logic [23:0] max_refs;
  } wdv_cfg_t;

  typedef struct packed {
    logic [4:0]  status;
    logic [15:0] table_count;
    logic        is_collection;
    logic [31:0] intermediate_total;
    logic [15:0] font_count;
  } wdv_result_t;

endpackage

### src/wdv_regs.sv
// APB register file holding the validator limits.
// Depends on wdv_pkg.
module wdv_regs
  import wdv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output wdv_cfg_t    cfg_o
);
  wdv_cfg_t cfg_q;
  logic [2:0] idx;
  logic wr;

  assign idx = paddr[4:2];
  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_input  <= 25'd16777216;
      cfg_q.max_final  <= 32'd67108864;
      cfg_q.max_inter  <= 32'd16777216;
      cfg_q.max_glyf   <= 32'd4194304;
      cfg_q.max_tables <= 16'd4096;
      cfg_q.max_fonts  <= 16'd256;
      cfg_q.max_refs   <= 24'd16384;
    end else if (wr) begin
      case (idx)
        RegMaxInput: cfg_q.max_input  <= pwdata[24:0];
        RegMaxFinal: cfg_q.max_final  <= pwdata;
        RegMaxInter: cfg_q.max_inter  <= pwdata;
        RegMaxGlyf:  cfg_q.max_glyf   <= pwdata;
        RegMaxTbl:   cfg_q.max_tables <= pwdata[15:0];
        RegMaxFonts: cfg_q.max_fonts  <= pwdata[15:0];
        RegMaxRefs:  cfg_q.max_refs   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegMaxInput: prdata = {7'd0, cfg_q.max_input};
      RegMaxFinal: prdata = cfg_q.max_final;
      RegMaxInter: prdata = cfg_q.max_inter;
      RegMaxGlyf:  prdata = cfg_q.max_glyf;
      RegMaxTbl:   prdata = {16'd0, cfg_q.max_tables};
      RegMaxFonts: prdata = {16'd0, cfg_q.max_fonts};
      RegMaxRefs:  prdata = {8'd0, cfg_q.max_refs};
      default:     prdata = 32'd0;
    endcase
  end
endmodule

### src/woff2_directory_validator_core.sv
// WOFF2 header and table directory validator, top level.
// Depends on wdv_pkg and wdv_regs.
//
//  channel  dir  fields
//  s_axis   in   tdata[7:0] byte_value, tlast last_byte
//  m_axis   out  tdata: status[4:0] table_count[20:5] is_collection[21]
//                intermediate_total[53:22] font_count[69:54], pad to 72
//  apb      in   seven limit registers at 4*i
//
// One byte per cycle; the parse state updates in the same cycle the byte is taken.
// The verdict is registered in an output stage; s_axis_tready stays high unless
// a verdict waits while a new last byte arrives.
// Reset clears the parse state and sets the limits to their defaults.
module woff2_directory_validator_core
  import wdv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_value
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // status, table_count, is_collection,
                                      // intermediate_total, font_count, zeros
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  wdv_cfg_t cfg;

  wdv_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  logic [3:0]  ph_q, ph_d;
  logic [24:0] cnt_q, cnt_d;
  logic [31:0] ws_q, ws_d, flav_q, flav_d, dlen_q, dlen_d, fsz_q, fsz_d;
  logic [15:0] tt_q, tt_d, rsv_q, rsv_d, left_q, left_d;
  logic [7:0]  flg_q, flg_d, pfx_q, pfx_d;
  logic [31:0] tag_q, tag_d, acc_q, acc_d;
  logic [2:0]  fb_q, fb_d;
  logic [32:0] isum_q, isum_d;
  logic [15:0] ftot_q, ftot_d, fleft_q, fleft_d;
  logic [24:0] refs_q, refs_d;
  logic [4:0]  err_q, err_d;

  logic        ovld_q;
  wdv_result_t res_q, res_d;

  logic acc_in;
  assign s_axis_tready = !ovld_q || m_axis_tready || !s_axis_tlast;
  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata = {2'd0, res_q.font_count, res_q.intermediate_total,
                         res_q.is_collection, res_q.table_count, res_q.status};

  logic [7:0]  b;
  logic [24:0] pos;
  logic [31:0] b128_acc, u32_acc, u255_val, tlen;
  logic [2:0]  fb_inc;
  logic        b128_err, b128_done, u32_done, u255_done, tr, is_gl;
  logic [32:0] isum_new;
  logic [25:0] refs_new;
  logic [5:0]  k;

  assign b = s_axis_tdata;
  assign pos = cnt_q;
  assign fb_inc = fb_q + 3'd1;
  assign b128_err = (fb_q == 3'd0 && b == 8'h80) || (acc_q[31:25] != 7'd0)
                    || (b[7] && fb_inc >= 3'd5);
  assign b128_acc = {acc_q[24:0], b[6:0]};
  assign b128_done = !b[7];
  assign u32_acc = {acc_q[23:0], b};
  assign u32_done = fb_inc >= 3'd4;
  assign is_gl = tag_q == TagGlyf || tag_q == TagLoca;
  assign tr = is_gl ? (flg_q[7:6] == 2'd0) : (flg_q[7:6] != 2'd0);
  assign tlen = b128_acc;
  assign isum_new = isum_q + {1'b0, tlen};
  assign k = b[5:0];

  always_comb begin
    u255_done = 1'b1;
    u255_val = 32'd0;
    if (fb_q == 3'd0) begin
      if (b >= 8'd253) u255_done = 1'b0;
      else u255_val = {24'd0, b};
    end else if (pfx_q == 8'd253) begin
      u255_val = {16'd0, acc_q[7:0], b};
      u255_done = fb_inc >= 3'd3;
    end else begin
      u255_val = {24'd0, b} + ((pfx_q == 8'd255) ? 32'd253 : 32'd506);
    end
  end

  assign refs_new = {1'b0, refs_q} + {10'd0, left_q};

  always_comb begin
    ph_d = ph_q; ws_d = ws_q; flav_d = flav_q; dlen_d = dlen_q; fsz_d = fsz_q;
    tt_d = tt_q; rsv_d = rsv_q; left_d = left_q; flg_d = flg_q; pfx_d = pfx_q;
    tag_d = tag_q; acc_d = acc_q; fb_d = fb_q; isum_d = isum_q;
    ftot_d = ftot_q; fleft_d = fleft_q; refs_d = refs_q; err_d = err_q;
    cnt_d = (cnt_q != CountMax) ? cnt_q + 25'd1 : cnt_q;
    if (err_q == 5'd0 || ph_q == PhHdr) begin
      case (ph_q)
        PhHdr: begin
          ws_d = {ws_q[23:0], b};
          if (pos == 25'd3 && ws_d != SigWoff2) begin
            if (err_q == 5'd0) err_d = StSig;
            ph_d = PhDone;
          end
          if (pos == 25'd7) flav_d = ws_d;
          if (pos == 25'd11) dlen_d = ws_d;
          if (pos == 25'd13) tt_d = ws_d[15:0];
          if (pos == 25'd15) rsv_d = ws_d[15:0];
          if (pos == 25'd19) fsz_d = ws_d;
          if (pos == 25'd47 && ph_d == PhHdr) begin
            left_d = tt_q; acc_d = '0; fb_d = '0;
            ph_d = (tt_q != 16'd0) ? PhFlags : PhDone;
          end
        end
        PhFlags: begin
          flg_d = b; acc_d = '0; fb_d = '0;
          if (k == 6'h3F) begin
            tag_d = '0; ph_d = PhTag;
          end else begin
            tag_d = (k == 6'd10) ? TagGlyf : ((k == 6'd11) ? TagLoca : 32'd0);
            ph_d = PhOrig;
          end
        end
        PhTag: begin
          acc_d = u32_acc; fb_d = fb_inc;
          if (u32_done) begin
            tag_d = u32_acc; acc_d = '0; fb_d = '0; ph_d = PhOrig;
          end
        end
        PhOrig, PhTlen: begin
          if (b128_err) begin
            err_d = StBadDir; ph_d = PhDone;
          end else begin
            acc_d = b128_acc;
            if (b[7]) fb_d = fb_inc;
            if (b128_done) begin
              if (ph_q == PhOrig && tr) begin
                acc_d = '0; fb_d = '0; ph_d = PhTlen;
              end else begin
                if (tag_q == TagLoca && ph_q == PhTlen && tlen != 32'd0) begin
                  err_d = StBadDir; ph_d = PhDone;
                end else if (tag_q == TagGlyf && ph_q == PhTlen && tlen > cfg.max_glyf) begin
                  err_d = StGlyfLim; ph_d = PhDone;
                end else if (isum_new > {1'b0, cfg.max_inter}) begin
                  err_d = StInterLim; ph_d = PhDone;
                end else begin
                  isum_d = isum_new; acc_d = '0; fb_d = '0;
                  left_d = left_q - 16'd1;
                  if (left_d != 16'd0) ph_d = PhFlags;
                  else ph_d = (flav_q == SigTtcf) ? PhCver : PhDone;
                end
              end
            end
          end
        end
        PhCver: begin
          acc_d = u32_acc; fb_d = fb_inc;
          if (u32_done) begin
            if (u32_acc != CVer1 && u32_acc != CVer2) begin
              err_d = StBadColl; ph_d = PhDone;
            end else begin
              acc_d = '0; fb_d = '0; ph_d = PhNfonts;
            end
          end
        end
        PhNfonts, PhFcount, PhFidx: begin
          if (fb_q == 3'd0 && !u255_done) begin
            pfx_d = b; fb_d = 3'd1; acc_d = '0;
          end else if (!u255_done) begin
            acc_d = u255_val; fb_d = fb_inc;
          end else begin
            acc_d = '0; fb_d = '0;
            if (ph_q == PhNfonts) begin
              if (u255_val == 32'd0) begin
                err_d = StBadColl; ph_d = PhDone;
              end else if (u255_val > {16'd0, cfg.max_fonts}) begin
                err_d = StFontCount; ph_d = PhDone;
              end else begin
                ftot_d = u255_val[15:0]; fleft_d = u255_val[15:0]; ph_d = PhFcount;
              end
            end else if (ph_q == PhFcount) begin
              left_d = u255_val[15:0];
              if (u255_val[15:0] == 16'd0) begin
                err_d = StBadColl; ph_d = PhDone;
              end else ph_d = PhFflav;
            end else begin
              if (u255_val >= {16'd0, tt_q}) begin
                err_d = StBadColl; ph_d = PhDone;
              end else begin
                left_d = left_q - 16'd1;
                if (left_d == 16'd0) begin
                  fleft_d = fleft_q - 16'd1;
                  ph_d = (fleft_d != 16'd0) ? PhFcount : PhDone;
                end
              end
            end
          end
        end
        PhFflav: begin
          acc_d = u32_acc; fb_d = fb_inc;
          if (u32_done) begin
            acc_d = '0; fb_d = '0;
            if (refs_new > {2'd0, cfg.max_refs}) begin
              err_d = StRefs; ph_d = PhDone;
            end else begin
              refs_d = refs_new[24:0]; ph_d = PhFidx;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // verdict uses state after this byte
  always_comb begin
    if (cnt_d == CountMax || cnt_d > cfg.max_input) res_d.status = StTooLarge;
    else if (cnt_d < 25'd4) res_d.status = StTooShort;
    else if (err_d == StSig) res_d.status = StSig;
    else if (cnt_d < 25'd48) res_d.status = StIncHdr;
    else if (dlen_d != {7'd0, cnt_d}) res_d.status = StLenMis;
    else if (tt_d == 16'd0) res_d.status = StNoTables;
    else if (rsv_d != 16'd0) res_d.status = StReserved;
    else if (fsz_d == 32'd0) res_d.status = StSizeZero;
    else if (fsz_d > cfg.max_final) res_d.status = StSizeLimit;
    else if (tt_d > cfg.max_tables) res_d.status = StTblCount;
    else if (err_d != 5'd0) res_d.status = err_d;
    else if (ph_d != PhDone) res_d.status = (ph_d <= PhTlen) ? StBadDir : StBadColl;
    else res_d.status = StOk;
    res_d.table_count = tt_d;
    res_d.is_collection = flav_d == SigTtcf;
    res_d.intermediate_total = isum_d[31:0];
    res_d.font_count = (flav_d == SigTtcf) ? ftot_d : 16'd0;
  end

  always_ff @(posedge clk_i) begin
    if (acc_in && s_axis_tlast) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (acc_in && s_axis_tlast) begin
      ovld_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhHdr; cnt_q <= '0; ws_q <= '0; flav_q <= '0; dlen_q <= '0;
      fsz_q <= '0; tt_q <= '0; rsv_q <= '0; left_q <= '0; flg_q <= '0;
      pfx_q <= '0; tag_q <= '0; acc_q <= '0; fb_q <= '0; isum_q <= '0;
      ftot_q <= '0; fleft_q <= '0; refs_q <= '0; err_q <= '0;
    end else if (acc_in) begin
      if (s_axis_tlast) begin
        ph_q <= PhHdr; cnt_q <= '0; ws_q <= '0; flav_q <= '0; dlen_q <= '0;
        fsz_q <= '0; tt_q <= '0; rsv_q <= '0; left_q <= '0; flg_q <= '0;
        pfx_q <= '0; tag_q <= '0; acc_q <= '0; fb_q <= '0; isum_q <= '0;
        ftot_q <= '0; fleft_q <= '0; refs_q <= '0; err_q <= '0;
      end else begin
        ph_q <= ph_d; cnt_q <= cnt_d; ws_q <= ws_d; flav_q <= flav_d;
        dlen_q <= dlen_d; fsz_q <= fsz_d; tt_q <= tt_d; rsv_q <= rsv_d;
        left_q <= left_d; flg_q <= flg_d; pfx_q <= pfx_d; tag_q <= tag_d;
        acc_q <= acc_d; fb_q <= fb_d; isum_q <= isum_d; ftot_q <= ftot_d;
        fleft_q <= fleft_d; refs_q <= refs_d; err_q <= err_d;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && !m_axis_tready |=> ovld_q) else $error("verdict dropped");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q && !m_axis_tready && s_axis_tlast |-> !s_axis_tready)
    else $error("verdict overrun");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q |-> res_q.status <= StRefs) else $error("bad status");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in && s_axis_tlast |=> cnt_q == '0 && ph_q == PhHdr)
    else $error("state not cleared");
endmodule

### tb/woff2_directory_validator_core_test.sv
// Testbench for woff2_directory_validator_core: streams whole WOFF2 files byte by byte
// and checks every verdict against an in-bench parser and font_rows. Depends on wdv_pkg and the RTL.
`timescale 1ns / 1ps

module woff2_directory_validator_core_test;
  import wdv_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef enum {
    CaseGood, CaseShort, CaseSig, CaseIncHdr, CaseLenMis, CaseNoTables, CaseReserved,
    CaseSizeZero, CaseSizeLimit, CaseTblCount, CaseTruncDir, CaseLocaBad, CaseGlyfBig,
    CaseInterBig, CaseCollVer, CaseFontCount, CaseRefs, CaseGoodColl, CaseTruncColl,
    CaseTrailing, CaseLeadPad, CaseTagged
  } font_case_e;

  typedef struct {
    font_case_e  kind;
    bit          typed;
    logic [4:0]  status;
  } font_row_t;

  font_row_t font_rows [0:21] = '{
    '{CaseGood, 1'b1, StOk},           '{CaseShort, 1'b1, StTooShort},
    '{CaseSig, 1'b1, StSig},           '{CaseIncHdr, 1'b1, StIncHdr},
    '{CaseLenMis, 1'b1, StLenMis},     '{CaseNoTables, 1'b1, StNoTables},
    '{CaseReserved, 1'b1, StReserved}, '{CaseSizeZero, 1'b1, StSizeZero},
    '{CaseSizeLimit, 1'b1, StSizeLimit}, '{CaseTblCount, 1'b1, StTblCount},
    '{CaseTruncDir, 1'b1, StBadDir},   '{CaseLocaBad, 1'b1, StBadDir},
    '{CaseGlyfBig, 1'b1, StGlyfLim},   '{CaseInterBig, 1'b1, StInterLim},
    '{CaseCollVer, 1'b1, StBadColl},   '{CaseFontCount, 1'b1, StFontCount},
    '{CaseRefs, 1'b1, StRefs},         '{CaseGoodColl, 1'b1, StOk},
    '{CaseTruncColl, 1'b1, StBadColl}, '{CaseTrailing, 1'b1, StOk},
    '{CaseLeadPad, 1'b1, StBadDir},    '{CaseTagged, 1'b0, StOk}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // byte_value
  logic        s_axis_tlast;   // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // status, table_count, is_collection,
                               // intermediate_total, font_count, zeros
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  woff2_directory_validator_core i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // parser copy
  wdv_cfg_t    lim;
  logic [3:0]  ph;
  logic [24:0] nbytes;
  logic [31:0] shreg, flavor, dlen, fsize, etag, acc;
  logic [15:0] ntab, resv, left, ftot, fleft;
  logic [7:0]  eflags, pfx;
  logic [2:0]  fb;
  logic [32:0] isum;
  logic [24:0] rsum;
  logic [4:0]  err;

  wdv_result_t verdict_q [$];
  logic [7:0]  font_q [$];
  int unsigned fails, cycles, hold_cnt, burst_left;
  bit          typed_ok;
  logic [4:0]  typed_st;

  // file generator knobs
  bit          k_coll, k_badidx, k_tame;
  int          k_entries, k_hdr, k_nfonts, k_fcount, k_force;
  logic [31:0] k_sfnt, k_cver;
  logic [15:0] k_resv;

  function automatic void clear_parse();
    ph = PhHdr; nbytes = '0; shreg = '0; flavor = '0; dlen = '0; ntab = '0; resv = '0;
    fsize = '0; left = '0; eflags = '0; etag = '0; acc = '0; fb = '0; pfx = '0;
    isum = '0; ftot = '0; fleft = '0; rsum = '0; err = '0;
  endfunction

  function automatic void fail_with(logic [4:0] code);
    if (err == StOk) err = code;
    ph = PhDone;
  endfunction

  function automatic int take_b128(logic [7:0] b);
    if ((fb == 0 && b == 8'h80) || (acc & 32'hFE000000) != 0) return -1;
    acc = {acc[24:0], b[6:0]};
    if (!b[7]) return 1;
    fb++;
    return (fb >= 5) ? -1 : 0;
  endfunction

  function automatic bit take_u255(logic [7:0] b);
    if (fb == 0) begin
      if (b >= 253) begin
        pfx = b; fb = 1; acc = '0;
        return 1'b0;
      end
      acc = {24'd0, b};
      return 1'b1;
    end
    if (pfx == 8'd253) begin
      acc = {16'd0, acc[7:0], b};
      fb++;
      return fb >= 3;
    end
    acc = b + ((pfx == 8'd255) ? 32'd253 : 32'd506);
    return 1'b1;
  endfunction

  function automatic bit take_u32(logic [7:0] b);
    acc = {acc[23:0], b};
    fb++;
    return fb >= 4;
  endfunction

  function automatic void close_entry(logic [31:0] tlen, bit tr);
    if (etag == TagLoca && tr && tlen != 0) begin fail_with(StBadDir); return; end
    if (etag == TagGlyf && tr && tlen > lim.max_glyf) begin fail_with(StGlyfLim); return; end
    if ({1'b0, isum} + tlen > {2'b0, lim.max_inter}) begin fail_with(StInterLim); return; end
    isum = isum + tlen;
    acc = '0; fb = '0;
    left = left - 16'd1;
    if (left != 0) ph = PhFlags;
    else ph = (flavor == SigTtcf) ? PhCver : PhDone;
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic [24:0] pos);
    int r;
    logic [31:0] v;
    logic [5:0] k;
    bit gl;
    case (ph)
      PhHdr: begin
        shreg = {shreg[23:0], b};
        if (pos == 3 && shreg != SigWoff2) fail_with(StSig);
        if (pos == 7) flavor = shreg;
        if (pos == 11) dlen = shreg;
        if (pos == 13) ntab = shreg[15:0];
        if (pos == 15) resv = shreg[15:0];
        if (pos == 19) fsize = shreg;
        if (pos == 47 && ph == PhHdr) begin
          left = ntab; acc = '0; fb = '0;
          ph = (ntab != 0) ? PhFlags : PhDone;
        end
      end
      PhFlags: begin
        eflags = b; acc = '0; fb = '0;
        k = b[5:0];
        if (k == 6'h3F) begin
          etag = '0; ph = PhTag;
        end else begin
          etag = (k == 6'd10) ? TagGlyf : ((k == 6'd11) ? TagLoca : 32'd0);
          ph = PhOrig;
        end
      end
      PhTag: begin
        if (take_u32(b)) begin
          etag = acc; acc = '0; fb = '0; ph = PhOrig;
        end
      end
      PhOrig: begin
        r = take_b128(b);
        if (r < 0) fail_with(StBadDir);
        else if (r > 0) begin
          gl = (etag == TagGlyf || etag == TagLoca);
          if (gl ? (eflags[7:6] == 0) : (eflags[7:6] != 0)) begin
            acc = '0; fb = '0; ph = PhTlen;
          end else close_entry(acc, 1'b0);
        end
      end
      PhTlen: begin
        r = take_b128(b);
        if (r < 0) fail_with(StBadDir);
        else if (r > 0) close_entry(acc, 1'b1);
      end
      PhCver: begin
        if (take_u32(b)) begin
          if (acc != CVer1 && acc != CVer2) fail_with(StBadColl);
          else begin
            acc = '0; fb = '0; ph = PhNfonts;
          end
        end
      end
      PhNfonts: begin
        if (take_u255(b)) begin
          v = acc; acc = '0; fb = '0;
          if (v == 0) fail_with(StBadColl);
          else if (v > lim.max_fonts) fail_with(StFontCount);
          else begin
            ftot = v[15:0]; fleft = v[15:0]; ph = PhFcount;
          end
        end
      end
      PhFcount: begin
        if (take_u255(b)) begin
          left = acc[15:0]; acc = '0; fb = '0;
          if (left == 0) fail_with(StBadColl);
          else ph = PhFflav;
        end
      end
      PhFflav: begin
        if (take_u32(b)) begin
          acc = '0; fb = '0;
          if ({1'b0, rsum} + left > {2'b0, lim.max_refs}) fail_with(StRefs);
          else begin
            rsum = rsum + left; ph = PhFidx;
          end
        end
      end
      PhFidx: begin
        if (take_u255(b)) begin
          v = acc; acc = '0; fb = '0;
          if (v >= ntab) fail_with(StBadColl);
          else begin
            left = left - 16'd1;
            if (left == 0) begin
              fleft = fleft - 16'd1;
              ph = (fleft != 0) ? PhFcount : PhDone;
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [4:0] font_verdict();
    if (nbytes == CountMax || nbytes > lim.max_input) return StTooLarge;
    if (nbytes < 4) return StTooShort;
    if (err == StSig) return StSig;
    if (nbytes < 48) return StIncHdr;
    if (dlen != {7'd0, nbytes}) return StLenMis;
    if (ntab == 0) return StNoTables;
    if (resv != 0) return StReserved;
    if (fsize == 0) return StSizeZero;
    if (fsize > lim.max_final) return StSizeLimit;
    if (ntab > lim.max_tables) return StTblCount;
    if (err != StOk) return err;
    if (ph != PhDone) return (ph <= PhTlen) ? StBadDir : StBadColl;
    return StOk;
  endfunction

  function automatic void take_byte(logic [7:0] b, logic is_last);
    logic [24:0] pos;
    wdv_result_t r;
    pos = nbytes;
    if (nbytes != CountMax) nbytes++;
    if (err == StOk || ph == PhHdr) parse_byte(b, pos);
    if (!is_last) return;
    r.status = typed_ok ? typed_st : font_verdict();
    r.table_count = ntab;
    r.is_collection = (flavor == SigTtcf);
    r.intermediate_total = isum[31:0];
    r.font_count = (flavor == SigTtcf) ? ftot : 16'd0;
    verdict_q.push_back(r);
    clear_parse();
  endfunction

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    wdv_result_t exp_r;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) take_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict with none pending: %h", m_axis_tdata);
          fails++;
        end else begin
          exp_r = verdict_q.pop_front();
          if (m_axis_tdata[4:0] !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, m_axis_tdata[4:0]); fails++;
          end
          if (m_axis_tdata[20:5] !== exp_r.table_count) begin
            $error("table_count exp %0d got %0d", exp_r.table_count, m_axis_tdata[20:5]);
            fails++;
          end
          if (m_axis_tdata[21] !== exp_r.is_collection) begin
            $error("is_collection exp %0d got %0d", exp_r.is_collection, m_axis_tdata[21]);
            fails++;
          end
          if (m_axis_tdata[53:22] !== exp_r.intermediate_total) begin
            $error("intermediate_total exp %0d got %0d", exp_r.intermediate_total,
                   m_axis_tdata[53:22]);
            fails++;
          end
          if (m_axis_tdata[69:54] !== exp_r.font_count) begin
            $error("font_count exp %0d got %0d", exp_r.font_count, m_axis_tdata[69:54]);
            fails++;
          end
        end
      end
    end
  end

  // receiver stall pattern plus the long hold-off
  always @(negedge clk_i) begin
    int unsigned mode;
    mode = (cycles / 97) % 4;
    if (hold_cnt > 0) begin
      m_axis_tready = 1'b0;
      hold_cnt--;
    end else begin
      case (mode)
        0: m_axis_tready = 1'b1;
        1: m_axis_tready = 1'($urandom_range(0, 1));
        2: m_axis_tready = ($urandom_range(0, 3) == 0);
        default: m_axis_tready = ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  function automatic void push32(logic [31:0] v);
    font_q.push_back(v[31:24]); font_q.push_back(v[23:16]);
    font_q.push_back(v[15:8]);  font_q.push_back(v[7:0]);
  endfunction

  function automatic void push_b128(logic [31:0] v);
    int n;
    logic [31:0] s;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    for (int i = n - 1; i >= 0; i--) begin
      s = v >> (7 * i);
      font_q.push_back({(i != 0), s[6:0]});
    end
  endfunction

  function automatic void push_u255(int unsigned v);
    int unsigned c;
    c = $urandom_range(0, 2);
    if (v < 253 && c != 0) font_q.push_back(v[7:0]);
    else if (v >= 253 && v < 506 && c == 1) begin
      font_q.push_back(8'd255); font_q.push_back(8'(v - 253));
    end else if (v >= 506 && v < 762 && c == 1) begin
      font_q.push_back(8'd254); font_q.push_back(8'(v - 506));
    end else begin
      font_q.push_back(8'd253); font_q.push_back(v[15:8]); font_q.push_back(v[7:0]);
    end
  endfunction

  function automatic logic [31:0] rand_len();
    if (k_tame) return $urandom_range(0, 300);
    case ($urandom_range(0, 5))
      0, 1, 2: return $urandom_range(0, 300);
      3, 4:    return $urandom_range(0, 1 << 21);
      default: return $urandom;
    endcase
  endfunction

  function automatic void patch_len();
    if (font_q.size() >= 12) begin
      font_q[8]  = 8'(font_q.size() >> 24); font_q[9]  = 8'(font_q.size() >> 16);
      font_q[10] = 8'(font_q.size() >> 8);  font_q[11] = 8'(font_q.size());
    end
  endfunction

  function automatic void push_entry(int forced);
    int unsigned pick;
    logic [7:0]  flags;
    logic [31:0] tag;
    bit          gl;
    pick = $urandom_range(0, 9);
    flags = {2'($urandom_range(0, 3)), 6'($urandom_range(0, 62))};
    if (pick < 3) flags[5:0] = 6'd10;
    else if (pick < 5) flags[5:0] = 6'd11;
    else if (pick < 7) flags[5:0] = 6'h3F;
    case (forced)
      1: flags = {2'd0, 6'd11};
      2: flags = {2'd0, 6'd10};
      3: flags = {2'd1, 6'd0};
      4: flags = {2'd0, 6'd1};
      default: ;
    endcase
    tag = (flags[5:0] == 6'd10) ? TagGlyf : ((flags[5:0] == 6'd11) ? TagLoca : 32'd0);
    font_q.push_back(flags);
    if (flags[5:0] == 6'h3F) begin
      case ($urandom_range(0, 2))
        0: tag = TagGlyf;
        1: tag = TagLoca;
        default: tag = $urandom;
      endcase
      push32(tag);
    end
    gl = (tag == TagGlyf || tag == TagLoca);
    if (forced == 4) font_q.push_back(8'h80);
    push_b128(rand_len());
    if (gl ? (flags[7:6] == 0) : (flags[7:6] != 0)) begin
      case (forced)
        1: push_b128(32'd5);
        2: push_b128(32'h00500000);
        3: push_b128(32'h02000000);
        default: push_b128((tag == TagLoca && (k_tame || $urandom_range(0, 7) != 0)) ?
                           32'd0 : rand_len());
      endcase
    end
  endfunction

  function automatic void set_knobs();
    k_coll = 0; k_badidx = 0; k_tame = 0; k_entries = 2; k_hdr = -1; k_nfonts = 1;
    k_fcount = 1; k_force = 0; k_sfnt = 32'd1000; k_cver = CVer1; k_resv = '0;
  endfunction

  function automatic void build_font();
    int nt;
    font_q.delete();
    nt = (k_hdr < 0) ? k_entries : k_hdr;
    push32(SigWoff2);
    push32(k_coll ? SigTtcf : (($urandom_range(0, 1) != 0) ? 32'h00010000 : $urandom));
    push32(32'd0);
    font_q.push_back(8'(nt >> 8)); font_q.push_back(8'(nt));
    font_q.push_back(k_resv[15:8]); font_q.push_back(k_resv[7:0]);
    push32(k_sfnt);
    repeat (28) font_q.push_back(8'($urandom));
    for (int i = 0; i < k_entries; i++) push_entry((i == 0) ? k_force : 0);
    if (k_coll) begin
      push32(k_cver);
      push_u255(k_nfonts);
      for (int f = 0; f < k_nfonts && f < 4; f++) begin
        push_u255(k_fcount);
        push32($urandom);
        for (int j = 0; j < k_fcount && j < 4; j++)
          push_u255(k_badidx ? $urandom_range(0, 300) : $urandom_range(0, nt - 1));
      end
    end
    patch_len();
  endfunction

  function automatic void build_case(font_case_e kind);
    set_knobs();
    k_tame = 1;
    case (kind)
      CaseNoTables:  begin k_hdr = 0; k_entries = 0; end
      CaseReserved:  k_resv = 16'hFFFF;
      CaseSizeZero:  k_sfnt = 32'd0;
      CaseSizeLimit: k_sfnt = 32'hFFFFFFFF;
      CaseTblCount:  begin k_hdr = 65535; k_entries = 1; end
      CaseLocaBad:   k_force = 1;
      CaseGlyfBig:   k_force = 2;
      CaseInterBig:  k_force = 3;
      CaseLeadPad:   k_force = 4;
      CaseCollVer:   begin k_coll = 1; k_cver = 32'h00030000; end
      CaseFontCount: begin k_coll = 1; k_nfonts = 300; end
      CaseRefs:      begin k_coll = 1; k_fcount = 20000; end
      CaseGoodColl, CaseTruncColl: begin k_coll = 1; k_nfonts = 2; k_fcount = 2; end
      CaseTagged:    k_entries = 5;
      default: ;
    endcase
    build_font();
    case (kind)
      CaseShort:     font_q = '{8'h77, 8'h4F, 8'h46};
      CaseSig:       font_q[0] = 8'h00;
      CaseIncHdr:    begin font_q = font_q[0:19]; patch_len(); end
      CaseLenMis:    font_q[11] = font_q[11] + 8'd1;
      CaseTruncDir:  begin font_q = font_q[0:49]; patch_len(); end
      CaseTruncColl: begin void'(font_q.pop_back()); patch_len(); end
      CaseTrailing:  begin repeat (5) font_q.push_back(8'($urandom)); patch_len(); end
      default: ;
    endcase
  endfunction

  function automatic void build_random();
    int unsigned m, n;
    set_knobs();
    k_coll = ($urandom_range(0, 9) < 4);
    k_entries = $urandom_range(1, 5);
    k_nfonts = $urandom_range(1, 3);
    k_fcount = $urandom_range(1, 3);
    k_cver = ($urandom_range(0, 1) != 0) ? CVer1 : CVer2;
    k_sfnt = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 100000) : $urandom;
    m = $urandom_range(0, 19);
    case (m)
      15: begin
        k_cver = ($urandom_range(0, 1) != 0) ? $urandom : CVer2;
        k_nfonts = $urandom_range(0, 1000); k_fcount = $urandom_range(0, 800);
      end
      16: k_hdr = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535) : $urandom_range(0, 8);
      17: begin k_coll = 1; k_badidx = 1; end
      18: begin
        k_resv = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'd0;
        k_sfnt = ($urandom_range(0, 1) != 0) ? 32'd0 : $urandom;
      end
      19: k_force = $urandom_range(1, 4);
      default: ;
    endcase
    build_font();
    n = font_q.size();
    case (m)
      11: font_q[$urandom_range(0, n - 1)] ^= 8'(1 << $urandom_range(0, 7));
      12: begin font_q = font_q[0:$urandom_range(0, n - 2)]; patch_len(); end
      13: begin repeat ($urandom_range(1, 8)) font_q.push_back(8'($urandom)); patch_len(); end
      14: begin
        font_q.delete();
        repeat ($urandom_range(1, 60)) font_q.push_back(8'($urandom));
      end
      default: ;
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b, logic is_last);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tlast = is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_font();
    foreach (font_q[i]) send_byte(font_q[i], i == font_q.size() - 1);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegMaxInput: lim.max_input  = val[24:0];
      RegMaxFinal: lim.max_final  = val;
      RegMaxInter: lim.max_inter  = val;
      RegMaxGlyf:  lim.max_glyf   = val;
      RegMaxTbl:   lim.max_tables = val[15:0];
      RegMaxFonts: lim.max_fonts  = val[15:0];
      RegMaxRefs:  lim.max_refs   = val[23:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_limits(logic [31:0] inp, logic [31:0] fin, logic [31:0] inter,
                            logic [31:0] glyf, logic [31:0] tbl, logic [31:0] fonts,
                            logic [31:0] refs);
    write_reg(RegMaxInput, inp); write_reg(RegMaxFinal, fin);
    write_reg(RegMaxInter, inter); write_reg(RegMaxGlyf, glyf);
    write_reg(RegMaxTbl, tbl); write_reg(RegMaxFonts, fonts); write_reg(RegMaxRefs, refs);
  endtask

  initial begin
    int unsigned phase_bytes;
    clk_i = 1'b0;
    rst_ni = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    fails = 0; cycles = 0; hold_cnt = 0; burst_left = 0; typed_ok = 0;
    lim = '{25'd16777216, 32'd67108864, 32'd16777216, 32'd4194304, 16'd4096, 16'd256,
            24'd16384};
    clear_parse();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (font_rows[i]) begin
      build_case(font_rows[i].kind);
      typed_ok = font_rows[i].typed;
      typed_st = font_rows[i].status;
      send_font();
      typed_ok = 1'b0;
    end

    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: set_limits(48, 1, 0, 0, 1, 1, 1);
        1: set_limits(32'd16777216, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 65535, 65535,
                      32'hFFFFFF);
        2: set_limits($urandom_range(48, 400), $urandom_range(1, 1 << 20),
                      $urandom_range(0, 5000), $urandom_range(0, 5000),
                      $urandom_range(1, 8), $urandom_range(1, 4), $urandom_range(1, 12));
        3: set_limits($urandom_range(200, 16777216), $urandom, $urandom, $urandom,
                      $urandom_range(1, 65535), $urandom_range(1, 65535),
                      $urandom_range(1, 16777215));
        default: set_limits(32'd16777216, 32'd67108864, 32'd16777216, 32'd4194304, 4096, 256,
                            16384);
      endcase
      if (p == 2) begin
        hold_cnt = 300;
        repeat (12) begin
          font_q.delete();
          repeat ($urandom_range(1, 4)) font_q.push_back(8'($urandom));
          send_font();
        end
      end
      phase_bytes = 0;
      while (phase_bytes < 60) begin
        build_random();
        send_font();
        phase_bytes += font_q.size();
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (fails == 0 && verdict_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### woff2_directory_validator_core.f
src/wdv_pkg.sv
src/wdv_regs.sv
src/woff2_directory_validator_core.sv
tb/woff2_directory_validator_core_test.sv
